>>> sv/ipbf_pkg.sv
// shared constants and types for the ipv4 blocklist packet filter
package ipbf_pkg;

    localparam int SourceEntriesDef = 32;
    localparam int BlockEntriesDef  = 32;

    // item opcodes
    localparam logic [1:0] OP_PACKET = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
    localparam logic [15:0] MIN_IP_LEN  = 16'd34;
    localparam logic [15:0] MIN_TCP_LEN = 16'd54;
    localparam logic [15:0] MIN_UDP_LEN = 16'd42;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // update command for one lru table
    typedef struct packed {
        logic ins;   // refresh on hit, insert on miss
        logic rfr;   // refresh only on hit
        logic rmv;   // remove on hit
    } t_tbl_cmd;

endpackage

>>> sv/ipbf_lru_table.sv
// exact-lru key table with parallel match, insert, refresh and remove
module ipbf_lru_table #(
    parameter int ENTRIES = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [31:0]                i_key,
    input  ipbf_pkg::t_tbl_cmd         i_cmd,
    input  logic                       i_en,
    output logic                       o_hit,
    output logic [$clog2(ENTRIES)-1:0] o_slot
);
    import ipbf_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] OldestAge = IW'(ENTRIES - 1);

    logic [31:0]   r_key   [ENTRIES];
    logic [IW-1:0] r_age   [ENTRIES];
    logic          r_valid [ENTRIES];

    logic          hit;
    logic [IW-1:0] hit_slot;
    logic [IW-1:0] free_slot;
    logic [IW-1:0] old_slot;
    logic          full;
    logic [IW-1:0] ins_slot;
    logic [IW-1:0] slot;
    logic [IW-1:0] rank;
    logic          rank_all;
    logic          do_touch;
    logic          do_ins;
    logic          do_rmv;

    // parallel match, free slot and oldest entry
    always_comb begin
        hit       = 1'b0;
        hit_slot  = '0;
        free_slot = '0;
        old_slot  = '0;
        full      = 1'b1;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && r_key[i] == i_key) begin
                hit      = 1'b1;
                hit_slot = IW'(i);
            end
            if (!r_valid[i]) begin
                full      = 1'b0;
                free_slot = IW'(i);
            end
            if (r_age[i] == OldestAge) begin
                old_slot = IW'(i);
            end
        end
    end

    assign ins_slot = full ? old_slot : free_slot;
    assign slot     = hit ? hit_slot : ins_slot;
    assign do_touch = i_en && hit && (i_cmd.ins || i_cmd.rfr);
    assign do_ins   = i_en && !hit && i_cmd.ins;
    assign do_rmv   = i_en && hit && i_cmd.rmv;
    // rank the touched entry held; a new entry into a free slot ages everyone
    assign rank     = hit ? r_age[hit_slot] : OldestAge;
    assign rank_all = do_ins && !full;

    // table update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
                r_age[i]   <= '0;
            end
        end else begin
            if (do_touch || do_ins) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IW'(i) == slot) begin
                        r_age[i]   <= '0;
                        r_valid[i] <= 1'b1;
                    end else if (r_valid[i] && (rank_all || r_age[i] < rank)) begin
                        r_age[i] <= r_age[i] + 1'b1;
                    end
                end
            end else if (do_rmv) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IW'(i) == hit_slot) begin
                        r_valid[i] <= 1'b0;
                        r_age[i]   <= '0;
                    end else if (r_valid[i] && r_age[i] > rank) begin
                        r_age[i] <= r_age[i] - 1'b1;
                    end
                end
            end
        end
    end

    // key storage
    always_ff @(posedge i_clk) begin
        if (do_ins) begin
            r_key[ins_slot] <= i_key;
        end
    end

    assign o_hit  = hit;
    assign o_slot = slot;

endmodule

>>> sv/ipv4_blocklist_packet_filter.sv
// top level of the ipv4 blocklist packet filter
//
// Input channel: i_in_valid / o_in_ready carry one item (opcode, frame length,
// ethertype, source address, protocol). Opcode 0 is a packet, 1 adds an
// address to the block table, 2 removes one. Output channel: o_out_valid /
// i_out_ready carry one result per item: the verdict, the per-source count
// and a snapshot of all statistics counters after the item.
// An accepted item sits in the input register, where both lru
// tables are matched in parallel and updated; the result register then holds
// the answer. o_out_valid rises once the item has moved from the input register
// into the result register, and one item is taken every cycle while the output
// keeps draining.
// When the receiver stalls, the result register holds its value, the input
// register holds the next item, and o_in_ready falls once both are full.
// Reset (synchronous, active low) empties both tables, clears all statistics
// counters, drops any item in flight; the block accepts items the cycle after.
module ipv4_blocklist_packet_filter #(
    parameter int SOURCE_ENTRIES = ipbf_pkg::SourceEntriesDef,
    parameter int BLOCK_ENTRIES  = ipbf_pkg::BlockEntriesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_frame_length,
    input  logic [15:0] i_ether_type,
    input  logic [31:0] i_source_address,
    input  logic [7:0]  i_ip_protocol,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_verdict,
    output logic [31:0] o_source_packet_count,
    output logic [31:0] o_passed_packets,
    output logic [31:0] o_dropped_packets,
    output logic [31:0] o_passed_bytes,
    output logic [31:0] o_tcp_packets,
    output logic [31:0] o_udp_packets,
    output logic [31:0] o_icmp_packets,
    output logic [31:0] o_other_packets
);
    import ipbf_pkg::*;

    localparam int SW = $clog2(SOURCE_ENTRIES);
    localparam int BW = $clog2(BLOCK_ENTRIES);

    // input register
    logic        r_s1_valid;
    logic [1:0]  r_op;
    logic [15:0] r_len;
    logic [15:0] r_etype;
    logic [31:0] r_addr;
    logic [7:0]  r_proto;

    logic s1_fire;
    logic in_fire;

    assign s1_fire    = r_s1_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op    <= i_opcode;
            r_len   <= i_frame_length;
            r_etype <= i_ether_type;
            r_addr  <= i_source_address;
            r_proto <= i_ip_protocol;
        end
    end

    // item decode
    logic counted;
    assign counted = (r_op == OP_PACKET) && (r_len >= MIN_IP_LEN) && (r_etype == ETYPE_IPV4);

    t_tbl_cmd src_cmd;
    t_tbl_cmd blk_cmd;
    logic          src_hit;
    logic [SW-1:0] src_slot;
    logic          blk_hit;
    logic [BW-1:0] blk_slot;

    always_comb begin
        src_cmd     = '0;
        src_cmd.ins = counted;
        blk_cmd     = '0;
        blk_cmd.rfr = counted;
        blk_cmd.ins = (r_op == OP_ADD);
        blk_cmd.rmv = (r_op == OP_REMOVE);
    end

    ipbf_lru_table #(.ENTRIES(SOURCE_ENTRIES)) u_src_tbl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (r_addr),
        .i_cmd   (src_cmd),
        .i_en    (s1_fire),
        .o_hit   (src_hit),
        .o_slot  (src_slot)
    );

    ipbf_lru_table #(.ENTRIES(BLOCK_ENTRIES)) u_blk_tbl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (r_addr),
        .i_cmd   (blk_cmd),
        .i_en    (s1_fire),
        .o_hit   (blk_hit),
        .o_slot  (blk_slot)
    );

    // per-source packet counts, indexed by table slot
    logic [31:0] r_src_cnt [SOURCE_ENTRIES];
    logic [31:0] src_cnt_new;

    assign src_cnt_new = src_hit ? r_src_cnt[src_slot] + 32'd1 : 32'd1;

    always_ff @(posedge i_clk) begin
        if (s1_fire && counted) begin
            r_src_cnt[src_slot] <= src_cnt_new;
        end
    end

    // statistics counters
    logic [31:0] r_pass, r_drop, r_bytes, r_tcp, r_udp, r_icmp, r_other;
    logic [31:0] n_pass, n_drop, n_bytes, n_tcp, n_udp, n_icmp, n_other;
    logic        drop;
    logic        pass;

    assign drop = counted && blk_hit;
    assign pass = counted && !blk_hit;

    always_comb begin
        n_pass  = r_pass;
        n_drop  = r_drop;
        n_bytes = r_bytes;
        n_tcp   = r_tcp;
        n_udp   = r_udp;
        n_icmp  = r_icmp;
        n_other = r_other;
        if (drop) begin
            n_drop = r_drop + 32'd1;
        end
        if (pass) begin
            n_pass  = r_pass + 32'd1;
            n_bytes = r_bytes + {16'd0, r_len};
            case (r_proto)
                PROTO_TCP: begin
                    if (r_len >= MIN_TCP_LEN) n_tcp = r_tcp + 32'd1;
                end
                PROTO_UDP: begin
                    if (r_len >= MIN_UDP_LEN) n_udp = r_udp + 32'd1;
                end
                PROTO_ICMP: begin
                    if (r_len >= MIN_UDP_LEN) n_icmp = r_icmp + 32'd1;
                end
                default: begin
                    n_other = r_other + 32'd1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass  <= '0;
            r_drop  <= '0;
            r_bytes <= '0;
            r_tcp   <= '0;
            r_udp   <= '0;
            r_icmp  <= '0;
            r_other <= '0;
        end else if (s1_fire) begin
            r_pass  <= n_pass;
            r_drop  <= n_drop;
            r_bytes <= n_bytes;
            r_tcp   <= n_tcp;
            r_udp   <= n_udp;
            r_icmp  <= n_icmp;
            r_other <= n_other;
        end
    end

    // result register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            o_verdict             <= drop;
            o_source_packet_count <= counted ? src_cnt_new : 32'd0;
            o_passed_packets      <= n_pass;
            o_dropped_packets     <= n_drop;
            o_passed_bytes        <= n_bytes;
            o_tcp_packets         <= n_tcp;
            o_udp_packets         <= n_udp;
            o_icmp_packets        <= n_icmp;
            o_other_packets       <= n_other;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> sv/ipbf_checker.sv
// port-level checks for the ipv4 blocklist packet filter
module ipbf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_verdict,
    input logic [31:0] o_source_packet_count,
    input logic [31:0] o_dropped_packets
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_verdict)
        && $stable(o_source_packet_count) && $stable(o_dropped_packets))
        else $error("stalled result changed");

    // input backpressure only with a stalled full output
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without output stall");

    // a dropped packet was counted against its source
    a_drop_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_verdict |-> o_source_packet_count != 32'd0)
        else $error("drop without source count");

    // reset empties the output
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind ipv4_blocklist_packet_filter ipbf_checker u_ipbf_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .o_in_ready            (o_in_ready),
    .o_out_valid           (o_out_valid),
    .i_out_ready           (i_out_ready),
    .o_verdict             (o_verdict),
    .o_source_packet_count (o_source_packet_count),
    .o_dropped_packets     (o_dropped_packets)
);
